### src/rvg_pkg.sv
// rvg_pkg: shared types, constants and the control store of the random variate generator.
// Holds the microcode table and entry points that the sequencer in the top level walks.
// No dependencies.
`timescale 1ns / 1ps

package rvg_pkg;

    // generator constants
    localparam logic [47:0] C_SEED_DEFAULT = 48'h1234_ABCD_330E;
    localparam logic [31:0] C_MUL_LO       = 32'hDEEC_E66D;
    localparam logic [2:0]  C_MUL_HI       = 3'h5;
    localparam logic [47:0] C_INC          = 48'hB;
    localparam int          C_UNIFORM_BITS = 32;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_MEAN   = 2'd1;
    localparam logic [1:0] REG_SPREAD = 2'd2;
    localparam logic [1:0] REG_DRAWS  = 2'd3;

    // modes
    localparam logic [1:0] MODE_GAUSS  = 2'd0;
    localparam logic [1:0] MODE_MAX    = 2'd1;
    localparam logic [1:0] MODE_MEDIAN = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_CLR     = 4'd1;
    localparam logic [3:0] OP_SUM     = 4'd2;
    localparam logic [3:0] OP_CENTRE  = 4'd3;
    localparam logic [3:0] OP_MULLO   = 4'd4;
    localparam logic [3:0] OP_MULHI   = 4'd5;
    localparam logic [3:0] OP_GFIN    = 4'd6;
    localparam logic [3:0] OP_MAX     = 4'd7;
    localparam logic [3:0] OP_OUTACC  = 4'd8;
    localparam logic [3:0] OP_SHIFT   = 4'd9;
    localparam logic [3:0] OP_MEDFIN  = 4'd10;
    localparam logic [3:0] OP_ZERO    = 4'd11;

    // generator advance control
    localparam logic [1:0] ADV_NO  = 2'd0;
    localparam logic [1:0] ADV_YES = 2'd1;
    localparam logic [1:0] ADV_CNT = 2'd2;

    // loop counter control
    localparam logic [2:0] CNT_HOLD  = 3'd0;
    localparam logic [2:0] CNT_LDSUM = 3'd1;
    localparam logic [2:0] CNT_LDMAX = 3'd2;
    localparam logic [2:0] CNT_LD1   = 3'd3;
    localparam logic [2:0] CNT_DEC   = 3'd4;

    // sequencing
    localparam logic [1:0] J_NEXT   = 2'd0;
    localparam logic [1:0] J_CNT_NZ = 2'd1;
    localparam logic [1:0] J_DONE   = 2'd2;

    localparam int          C_PC_W    = 4;
    localparam logic [3:0]  C_LAST_PC = 4'd13;

    typedef struct packed {
        logic [3:0]        op;
        logic [1:0]        adv;
        logic [2:0]        cnt;
        logic [1:0]        jmp;
        logic [C_PC_W-1:0] tgt;
    } t_cword;

    typedef struct packed {
        logic        load;
        logic        adv;
        logic [47:0] seed;
    } t_lcg_ctrl;

    function automatic t_cword f_ucode(input logic [C_PC_W-1:0] pc);
        t_cword w;
        w = '{op: OP_NOP, adv: ADV_NO, cnt: CNT_HOLD, jmp: J_DONE, tgt: '0};
        case (pc)
            // gaussian
            4'd0:  w = '{op: OP_CLR,    adv: ADV_YES, cnt: CNT_LDSUM, jmp: J_NEXT,   tgt: 4'd0};
            4'd1:  w = '{op: OP_SUM,    adv: ADV_CNT, cnt: CNT_DEC,   jmp: J_CNT_NZ, tgt: 4'd1};
            4'd2:  w = '{op: OP_CENTRE, adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_NEXT,   tgt: 4'd0};
            4'd3:  w = '{op: OP_MULLO,  adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_NEXT,   tgt: 4'd0};
            4'd4:  w = '{op: OP_MULHI,  adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_NEXT,   tgt: 4'd0};
            4'd5:  w = '{op: OP_GFIN,   adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_DONE,   tgt: 4'd0};
            // maximum of draws
            4'd6:  w = '{op: OP_CLR,    adv: ADV_YES, cnt: CNT_LDMAX, jmp: J_NEXT,   tgt: 4'd0};
            4'd7:  w = '{op: OP_MAX,    adv: ADV_CNT, cnt: CNT_DEC,   jmp: J_CNT_NZ, tgt: 4'd7};
            4'd8:  w = '{op: OP_OUTACC, adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_DONE,   tgt: 4'd0};
            // median of three
            4'd9:  w = '{op: OP_NOP,    adv: ADV_YES, cnt: CNT_LD1,   jmp: J_NEXT,   tgt: 4'd0};
            4'd10: w = '{op: OP_SHIFT,  adv: ADV_CNT, cnt: CNT_DEC,   jmp: J_CNT_NZ, tgt: 4'd10};
            4'd11: w = '{op: OP_NOP,    adv: ADV_YES, cnt: CNT_HOLD,  jmp: J_NEXT,   tgt: 4'd0};
            4'd12: w = '{op: OP_MEDFIN, adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_DONE,   tgt: 4'd0};
            // unused mode
            4'd13: w = '{op: OP_ZERO,   adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_DONE,   tgt: 4'd0};
            default: w = '{op: OP_ZERO, adv: ADV_NO,  cnt: CNT_HOLD,  jmp: J_DONE,   tgt: 4'd0};
        endcase
        return w;
    endfunction

    function automatic logic [C_PC_W-1:0] f_entry(input logic [1:0] mode);
        logic [C_PC_W-1:0] pc;
        case (mode)
            MODE_GAUSS:  pc = 4'd0;
            MODE_MAX:    pc = 4'd6;
            MODE_MEDIAN: pc = 4'd9;
            default:     pc = 4'd13;
        endcase
        return pc;
    endfunction

endpackage

### src/random_variate_generator.sv
// random_variate_generator: microcoded sequencer and datapath drawing gaussian, max or median
// variates from a 48-bit LCG. Depends on rvg_pkg and rvg_lcg.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_stall    | i_reseed, i_new_seed
//  out     | from block| o_out_valid / i_out_stall  | o_sample
//  cfg     | to block  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item at a time. Gaussian sums SUM_TERMS draws and scales on the shared 20x31 multiplier;
// maximum keeps the largest of max(draw_count,1) draws, median the middle of three, unused mode
// gives zero. The generator advances one draw a cycle when asked, via one multiply-accumulate.
// Synchronous active-low reset restores the default seed and register values.
// A finished result sits in the output register; the final step waits only if that is still full.
`timescale 1ns / 1ps

module random_variate_generator #(
    parameter int SUM_TERMS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_reseed,
    input  logic [47:0] i_new_seed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [63:0] o_sample,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import rvg_pkg::*;

    localparam int          SUM_W  = 32 + $clog2(SUM_TERMS);
    localparam int          MW     = SUM_W - 16;
    localparam int          PW     = MW + 31;
    localparam logic [63:0] HALF64 = 64'(SUM_TERMS) << 31;
    localparam logic [SUM_W-1:0] HALF = HALF64[SUM_W-1:0];
    localparam int          UKEEP  = (C_UNIFORM_BITS < 32) ? C_UNIFORM_BITS : 32;
    localparam logic [31:0] UMASK  = ~(32'hFFFF_FFFF >> UKEEP);

    // control and configuration
    logic              r_busy, n_busy;
    logic [C_PC_W-1:0] r_pc, n_pc;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_mode;
    logic signed [31:0] r_mean;
    logic [30:0]       r_sigma;
    logic [7:0]        r_draws;
    logic [7:0]        r_cnt, n_cnt;

    // payload
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [SUM_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [PW-1:0]     r_lo, n_lo;
    logic [PW-1:0]     r_hi, n_hi;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_b, n_b;
    logic [63:0]       r_out, n_out;

    t_cword            w_cw;
    t_lcg_ctrl         w_lcg;
    logic [47:0]       w_state;
    logic [31:0]       w_u;
    logic              w_accept, w_hold, w_step, w_cnt_nz;
    logic [MW-1:0]     w_mop;
    logic [PW-1:0]     w_prod;
    logic [PW:0]       w_q;
    logic [63:0]       w_scaled, w_mu;
    logic [31:0]       w_lo3, w_hi3, w_med;

    rvg_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_lcg),
        .o_state (w_state)
    );

    assign w_cw     = f_ucode(r_pc);
    assign w_u      = w_state[47:16] & UMASK;
    assign w_accept = i_in_valid && !r_busy;
    assign w_hold   = r_busy && (w_cw.jmp == J_DONE) && r_ovalid && i_out_stall;
    assign w_step   = r_busy && !w_hold;
    assign w_cnt_nz = (r_cnt != 8'd0);

    assign w_lcg.load = w_accept && i_reseed;
    assign w_lcg.seed = i_new_seed;
    assign w_lcg.adv  = w_step && ((w_cw.adv == ADV_YES) || (w_cw.adv == ADV_CNT && w_cnt_nz));

    // shared multiplier
    assign w_mop  = (w_cw.op == OP_MULHI) ? r_mag[SUM_W-1:16] : MW'(r_mag[15:0]);
    assign w_prod = PW'(w_mop) * PW'(r_sigma);

    assign w_q      = (PW+1)'(r_hi) + (PW+1)'(r_lo[PW-1:16])
                    + (PW+1)'(r_neg && (r_lo[15:0] != 16'd0));
    assign w_scaled = r_neg ? (64'd0 - 64'(w_q)) : 64'(w_q);
    assign w_mu     = {{16{r_mean[31]}}, r_mean, 16'b0};

    // median of r_b, r_a and the newest draw
    assign w_lo3 = (r_b < r_a) ? r_b : r_a;
    assign w_hi3 = (r_b < r_a) ? r_a : r_b;
    assign w_med = (w_lo3 > ((w_hi3 < w_u) ? w_hi3 : w_u)) ? w_lo3 : ((w_hi3 < w_u) ? w_hi3 : w_u);

    always_comb begin
        n_busy   = r_busy;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_out_stall;
        n_acc    = r_acc;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_a      = r_a;
        n_b      = r_b;
        n_out    = r_out;

        if (w_accept) begin
            n_busy = 1'b1;
            n_pc   = f_entry(r_mode);
        end

        if (w_step) begin
            case (w_cw.op)
                OP_CLR:    n_acc = '0;
                OP_SUM:    n_acc = r_acc + SUM_W'(w_u);
                OP_CENTRE: begin
                    n_neg = (r_acc < HALF);
                    n_mag = (r_acc < HALF) ? (HALF - r_acc) : (r_acc - HALF);
                end
                OP_MULLO:  n_lo = w_prod;
                OP_MULHI:  n_hi = w_prod;
                OP_GFIN:   n_out = w_scaled + w_mu;
                OP_MAX:    if (w_u > r_acc[31:0]) n_acc = SUM_W'(w_u);
                OP_OUTACC: n_out = 64'(r_acc[31:0]);
                OP_SHIFT: begin
                    n_b = r_a;
                    n_a = w_u;
                end
                OP_MEDFIN: n_out = 64'(w_med);
                OP_ZERO:   n_out = '0;
                default:   n_acc = r_acc;
            endcase

            case (w_cw.cnt)
                CNT_LDSUM: n_cnt = 8'(SUM_TERMS - 1);
                CNT_LDMAX: n_cnt = (r_draws == 8'd0) ? 8'd0 : (r_draws - 8'd1);
                CNT_LD1:   n_cnt = 8'd1;
                CNT_DEC:   if (w_cnt_nz) n_cnt = r_cnt - 8'd1;
                default:   n_cnt = r_cnt;
            endcase

            case (w_cw.jmp)
                J_CNT_NZ: n_pc = w_cnt_nz ? w_cw.tgt : (r_pc + 1'b1);
                J_DONE: begin
                    n_busy   = 1'b0;
                    n_ovalid = 1'b1;
                end
                default:  n_pc = r_pc + 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_mode   <= MODE_GAUSS;
            r_mean   <= '0;
            r_sigma  <= 31'd65536;
            r_draws  <= 8'd1;
        end else begin
            r_busy   <= n_busy;
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:   r_mode  <= i_cfg_data[1:0];
                    REG_MEAN:   r_mean  <= i_cfg_data;
                    REG_SPREAD: r_sigma <= i_cfg_data[30:0];
                    REG_DRAWS:  r_draws <= i_cfg_data[7:0];
                    default:    r_mode  <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_a   <= n_a;
        r_b   <= n_b;
        r_out <= n_out;
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_ovalid;
    assign o_sample    = r_out;

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && r_pc == f_entry(r_mode)))
        else $error("sequencer did not start at the mode entry");

    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_busy))
        else $error("result appeared without a running sequence");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= C_LAST_PC))
        else $error("step counter left the control store");

    a_cnt_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_cw.cnt == CNT_DEC && w_cnt_nz) |=> (r_cnt == $past(r_cnt) - 8'd1))
        else $error("loop counter did not count down");

endmodule

### src/rvg_lcg.sv
// rvg_lcg: 48-bit linear congruential generator state with seed load and a combinational step.
// Step is a 32x32 multiply-accumulate plus narrow cross terms, all modulo 2^48.
// Depends on rvg_pkg.
`timescale 1ns / 1ps

module rvg_lcg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rvg_pkg::t_lcg_ctrl i_ctrl,
    output logic [47:0]        o_state
);
    import rvg_pkg::*;

    logic [47:0] r_state;
    logic [47:0] n_state;
    logic [63:0] w_prod;
    logic [15:0] w_cross;

    // only the low 16 bits of the cross terms survive the 2^48 wrap
    always_comb begin
        w_prod  = r_state[31:0] * C_MUL_LO;
        w_cross = 16'(r_state[47:32] * C_MUL_LO[15:0])
                + 16'(r_state[15:0] * 16'(C_MUL_HI));
        n_state = r_state;
        if (i_ctrl.load) begin
            n_state = i_ctrl.seed;
        end else if (i_ctrl.adv) begin
            n_state = w_prod[47:0] + {w_cross, 32'b0} + C_INC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_SEED_DEFAULT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

### sim/random_variate_generator_tb.sv
// random_variate_generator_tb: self-checking testbench for the random variate generator.
// Runs its own 48-bit LCG predictor against the DUT under random handshake idling and stalls.
// Depends on rvg_pkg and random_variate_generator.
`timescale 1ns / 1ps

module random_variate_generator_tb;
    import rvg_pkg::*;

    localparam int          GAUSS_TERMS  = 12;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [47:0] LCG_MULT     = {13'b0, C_MUL_HI, C_MUL_LO};
    localparam int          TARGET_ITEMS = 1950;
    localparam int          LONG_HOLD    = 300;

    typedef struct packed {
        logic        reseed;
        logic [47:0] seed;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_reseed = 1'b0;
    logic [47:0] i_new_seed = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [63:0] o_sample;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    // predictor state and registers
    logic [47:0] gen_state = C_SEED_DEFAULT;
    logic [1:0]  mode_reg = MODE_GAUSS;
    logic [31:0] mean_reg = '0;
    logic [30:0] spread_reg = 31'd65536;
    logic [7:0]  draws_reg = 8'd1;

    t_request    pending_requests[$];
    logic [63:0] expected_samples[$];

    int unsigned offered_n = 0;
    int unsigned accepted_n = 0;
    int unsigned queued_n = 0;
    int unsigned error_n = 0;
    int unsigned hold_requests = 0;
    bit          send_en = 1'b0;
    bit          idle_on = 1'b1;

    random_variate_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_reseed    (i_reseed),
        .i_new_seed  (i_new_seed),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] next_uniform();
        gen_state = gen_state * LCG_MULT + 48'hB;
        return gen_state[47:16];
    endfunction

    function automatic logic [63:0] gauss_variate();
        logic [63:0] acc, half, mag, xh, xl, lowprod, q, mu;
        logic        neg;
        acc = '0;
        for (int k = 0; k < GAUSS_TERMS; k++) begin
            acc = acc + {32'b0, next_uniform()};
        end
        half = 64'(GAUSS_TERMS) << 31;
        neg = acc < half;
        mag = neg ? half - acc : acc - half;
        xh = mag >> 16;
        xl = {48'b0, mag[15:0]};
        lowprod = xl * {33'b0, spread_reg};
        q = xh * {33'b0, spread_reg} + (lowprod >> 16);
        if (neg && lowprod[15:0] != 16'd0) begin
            q = q + 64'd1;
        end
        mu = {{16{mean_reg[31]}}, mean_reg, 16'b0};
        return (neg ? -q : q) + mu;
    endfunction

    function automatic logic [63:0] max_variate();
        logic [31:0] best, v;
        int          n;
        n = (draws_reg == 8'd0) ? 1 : int'(draws_reg);
        best = next_uniform();
        for (int k = 1; k < n; k++) begin
            v = next_uniform();
            if (v > best) begin
                best = v;
            end
        end
        return {32'b0, best};
    endfunction

    function automatic logic [63:0] median_variate();
        logic [31:0] a, b, c, t;
        a = next_uniform();
        b = next_uniform();
        c = next_uniform();
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        if (b > c) begin
            b = c;
        end
        if (a > b) begin
            b = a;
        end
        return {32'b0, b};
    endfunction

    function automatic logic [63:0] predict_variate(input logic reseed, input logic [47:0] seed);
        logic [63:0] s;
        if (reseed) begin
            gen_state = seed;
        end
        case (mode_reg)
            MODE_GAUSS:  s = gauss_variate();
            MODE_MAX:    s = max_variate();
            MODE_MEDIAN: s = median_variate();
            default:     s = '0;
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $time, msg);
        error_n++;
    endtask

    // sender: bursts of random length, random gaps between them
    always @(negedge i_clk) begin : sender
        t_request   req;
        logic       next_valid;
        logic       next_reseed;
        logic [47:0] next_seed;
        static int  burst_left = 1;
        static int  gap_left = 0;
        next_valid = i_in_valid;
        next_reseed = i_reseed;
        next_seed = i_new_seed;
        if (accepted_n == offered_n) begin
            next_valid = 1'b0;
            next_reseed = 1'($urandom);
            next_seed = {16'($urandom), 32'($urandom)};
            if (gap_left > 0) begin
                gap_left--;
            end else if (send_en && pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                next_valid = 1'b1;
                next_reseed = req.reseed;
                next_seed = req.seed;
                offered_n++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = idle_on ? $urandom_range(0, 12) : 0;
                end
            end
        end
        i_in_valid <= next_valid;
        i_reseed <= next_reseed;
        i_new_seed <= next_seed;
    end

    // receiver: stall windows on a pattern, plus an occasional long hold
    always @(negedge i_clk) begin : receiver
        logic              stall_sel;
        static int unsigned hold_served = 0;
        static int         hold_left = 0;
        static int         window_left = 0;
        static int         stall_kind = 0;
        static logic [15:0] stall_pat = '0;
        stall_sel = 1'b0;
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_sel = 1'b1;
        end else begin
            if (window_left == 0) begin
                window_left = $urandom_range(8, 64);
                stall_kind = $urandom_range(0, 3);
                stall_pat = 16'($urandom);
            end else begin
                window_left--;
            end
            case (stall_kind)
                1: stall_sel = 1'($urandom);
                2: begin
                    stall_sel = stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[15:1]};
                end
                3: stall_sel = ($urandom_range(0, 3) == 0);
                default: stall_sel = 1'b0;
            endcase
        end
        i_out_stall <= stall_sel;
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin : monitor
        logic [63:0] want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                accepted_n++;
                expected_samples.push_back(predict_variate(i_reseed, i_new_seed));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %h", o_sample));
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample !== want) begin
                        report_mismatch($sformatf("sample got %h, expected %h", o_sample, want));
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_MODE:   mode_reg = value[1:0];
            REG_MEAN:   mean_reg = value;
            REG_SPREAD: spread_reg = value[30:0];
            REG_DRAWS:  draws_reg = value[7:0];
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_data <= $urandom;
    endtask

    task automatic queue_request(input logic reseed, input logic [47:0] seed);
        pending_requests.push_back('{reseed: reseed, seed: seed});
        queued_n++;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || accepted_n != offered_n
               || expected_samples.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [1:0]  m;
        logic [31:0] mean_v, spread_v, draws_v;
        int          n_items, reseed_pct, r, phase;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_en = 1'b1;

        // reset configuration, default seed first
        queue_request(1'b0, 48'h0);
        queue_request(1'b1, 48'h0);
        queue_request(1'b1, 48'hFFFF_FFFF_FFFF);
        wait_drained();

        // gaussian extremes of mean and spread
        write_reg(REG_MODE, {30'b0, MODE_GAUSS});
        write_reg(REG_MEAN, 32'h7FFF_FFFF);
        write_reg(REG_SPREAD, 32'h7FFF_FFFF);
        queue_request(1'b1, 48'h0);
        queue_request(1'b1, 48'hFFFF_FFFF_FFFF);
        queue_request(1'b0, 48'h5555_AAAA_5555);
        wait_drained();
        write_reg(REG_MEAN, 32'h8000_0000);
        write_reg(REG_SPREAD, 32'h0);
        queue_request(1'b1, 48'hAAAA_5555_AAAA);
        queue_request(1'b0, 48'h0);
        wait_drained();
        write_reg(REG_SPREAD, 32'hFFFF_FFFF);
        queue_request(1'b0, 48'h0);
        queue_request(1'b1, 48'h8000_0000_0001);
        wait_drained();

        // maximum: zero draws behaves as one, then the largest count
        write_reg(REG_MODE, {30'b0, MODE_MAX});
        write_reg(REG_DRAWS, 32'h0);
        queue_request(1'b1, 48'h1234_5678_9ABC);
        queue_request(1'b0, 48'h0);
        wait_drained();
        write_reg(REG_DRAWS, 32'hFFFF_FFFF);
        queue_request(1'b0, 48'h0);
        wait_drained();
        write_reg(REG_DRAWS, 32'd2);
        queue_request(1'b0, 48'h0);
        queue_request(1'b1, 48'hFFFF_FFFF_FFFF);
        wait_drained();

        write_reg(REG_MODE, {30'b0, MODE_MEDIAN});
        queue_request(1'b1, 48'h0);
        queue_request(1'b0, 48'h0);
        queue_request(1'b1, 48'hFFFF_FFFF_FFFF);
        wait_drained();

        // unused mode gives zero but still reseeds
        write_reg(REG_MODE, 32'hFFFF_FFFF);
        queue_request(1'b1, 48'hDEAD_BEEF_CAFE);
        queue_request(1'b0, 48'h0);
        wait_drained();
        write_reg(REG_MODE, {30'b0, MODE_MEDIAN});
        queue_request(1'b0, 48'h0);
        wait_drained();

        // random phases
        phase = 0;
        while (queued_n < TARGET_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r == 0) m = MODE_UNUSED;
            else if (r <= 8) m = MODE_GAUSS;
            else if (r <= 14) m = MODE_MAX;
            else m = MODE_MEDIAN;

            r = $urandom_range(0, 7);
            if (r == 0) mean_v = 32'h8000_0000;
            else if (r == 1) mean_v = 32'h7FFF_FFFF;
            else if (r == 2) mean_v = 32'h0;
            else mean_v = $urandom;

            r = $urandom_range(0, 7);
            if (r == 0) spread_v = {1'($urandom), 31'h0};
            else if (r == 1) spread_v = {1'($urandom), 31'h7FFF_FFFF};
            else if (r == 2) spread_v = 32'd65536;
            else if (r == 3) spread_v = $urandom;
            else spread_v = $urandom_range(0, 32'h0004_0000);

            r = $urandom_range(0, 19);
            if (r == 0) draws_v = 32'd0;
            else if (r == 1) draws_v = 32'd255;
            else if (r == 2) draws_v = $urandom_range(9, 254);
            else draws_v = $urandom_range(1, 8);
            draws_v[31:8] = 24'($urandom);

            write_reg(REG_DRAWS, draws_v);
            write_reg(REG_SPREAD, spread_v);
            write_reg(REG_MEAN, mean_v);
            write_reg(REG_MODE, {30'($urandom), m});

            n_items = (m == MODE_MAX && draws_v[7:0] > 8'd32) ? 4 : $urandom_range(20, 80);
            r = $urandom_range(0, 3);
            reseed_pct = (r == 0) ? 0 : (r == 1) ? 10 : (r == 2) ? 50 : 100;
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 3 || phase == 20) begin
                hold_requests++;
            end
            for (int k = 0; k < n_items; k++) begin
                queue_request($urandom_range(0, 99) < reseed_pct,
                              {16'($urandom), 32'($urandom)});
            end
            wait_drained();
            phase++;
        end

        repeat (40) @(negedge i_clk);
        if (error_n == 0) begin
            $display("random_variate_generator_tb: clean");
        end else begin
            $display("random_variate_generator_tb: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("random_variate_generator_tb: errors");
        $finish;
    end

endmodule
